[rtl/core/qxmm_pkg.sv]
package qxmm_pkg;

  localparam int FRAC_BITS = 12;
  localparam int ONE       = 1 << FRAC_BITS;

  localparam int NMOT      = 4;
  localparam int MI_W      = 2;
  localparam int ACT_W     = 3;
  localparam int IDX_W     = 3;
  localparam int CMD_W     = 16;
  localparam int PWM_W     = 16;
  localparam int LVL_W     = FRAC_BITS + 1;
  localparam int DEM_W     = FRAC_BITS + 2;
  // twice the throttle plus three half-gain demands, with sign
  localparam int M2_W      = FRAC_BITS + 5;

  // shared multiplier operands and product
  localparam int MUL_A_W   = PWM_W + 2;
  localparam int MUL_B_W   = LVL_W + 1;
  localparam int MUL_W     = MUL_A_W + MUL_B_W;

  // shared restoring divider
  localparam int QUO_W     = FRAC_BITS + 3;
  localparam int NUM_W     = PWM_W + FRAC_BITS;
  localparam int DEN_W     = PWM_W + 1;
  localparam int DSH_W     = DEN_W + QUO_W;
  localparam int CNT_W     = $clog2(QUO_W);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [PWM_W-1:0] PWM_FLOOR_RST   = PWM_W'(1000);
  localparam logic [PWM_W-1:0] PWM_CEILING_RST = PWM_W'(2000);
  localparam logic [LVL_W-1:0] DESAT_MIN_RST   = LVL_W'(205);
  localparam logic [LVL_W-1:0] IDLE_LEVEL_RST  = LVL_W'(246);
  localparam logic [LVL_W-1:0] LVL_ONE         = LVL_W'(ONE);

  typedef enum logic [ACT_W-1:0] {
    ACT_MIX     = 3'd0,
    ACT_ARM     = 3'd1,
    ACT_DISARM  = 3'd2,
    ACT_SET_PWM = 3'd3,
    ACT_SET_ALL = 3'd4,
    ACT_IDLE    = 3'd5,
    ACT_STOP    = 3'd6,
    ACT_UPDATE  = 3'd7
  } act_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PWM_FLOOR   = 2'd0,
    CFG_PWM_CEILING = 2'd1,
    CFG_DESAT_MIN   = 2'd2,
    CFG_IDLE_LEVEL  = 2'd3
  } cfg_reg_t;

  function automatic logic [LVL_W-1:0] clamp_thr(input logic signed [CMD_W-1:0] v);
    logic [LVL_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > CMD_W'(ONE)) begin
      res = LVL_ONE;
    end else begin
      res = v[LVL_W-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [DEM_W-1:0] clamp_dem(input logic signed [CMD_W-1:0] v);
    logic signed [DEM_W-1:0] res;
    if (v > CMD_W'(ONE)) begin
      res = DEM_W'(ONE);
    end else if (v < -CMD_W'(ONE)) begin
      res = -DEM_W'(ONE);
    end else begin
      res = v[DEM_W-1:0];
    end
    return res;
  endfunction

endpackage

[rtl/core/quad_x_motor_mixer.sv]
// quad x motor mixer: one item at a time, shared 18x14 multiplier and restoring divider (15
// quotient bits, one per cycle). arm/disarm/stop/update and set_pwm to an absent motor load
// the result directly; idle scales its level to a pulse; set_pwm/set_all_pwm divide for the level
// when span > 0 and pulse > floor; mix takes motors in turn, rescaling when desaturating. in_stall
// is high from acceptance until the result is loaded, so a new item waits for the last one.
// rst_n (synchronous) restores register defaults, disarms, zeroes levels, pulses to floor.
module quad_x_motor_mixer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [qxmm_pkg::ACT_W-1:0]            in_action,
  input  logic signed [qxmm_pkg::CMD_W-1:0]     in_throttle_cmd,
  input  logic signed [qxmm_pkg::CMD_W-1:0]     in_roll_cmd,
  input  logic signed [qxmm_pkg::CMD_W-1:0]     in_pitch_cmd,
  input  logic signed [qxmm_pkg::CMD_W-1:0]     in_yaw_cmd,
  input  logic [qxmm_pkg::IDX_W-1:0]            in_motor_index,
  input  logic [qxmm_pkg::PWM_W-1:0]            in_pwm_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [qxmm_pkg::PWM_W-1:0]            out_pwm_motor1,
  output logic [qxmm_pkg::PWM_W-1:0]            out_pwm_motor2,
  output logic [qxmm_pkg::PWM_W-1:0]            out_pwm_motor3,
  output logic [qxmm_pkg::PWM_W-1:0]            out_pwm_motor4,
  output logic [qxmm_pkg::LVL_W-1:0]            out_level_motor1,
  output logic [qxmm_pkg::LVL_W-1:0]            out_level_motor2,
  output logic [qxmm_pkg::LVL_W-1:0]            out_level_motor3,
  output logic [qxmm_pkg::LVL_W-1:0]            out_level_motor4,
  output logic                                  out_is_armed,
  output logic                                  out_levels_pushed,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [qxmm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [qxmm_pkg::CFG_DAT_W-1:0]        cfg_data
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_SUM     = 12'b0000_0000_0010,
    S_MAX     = 12'b0000_0000_0100,
    S_LVL     = 12'b0000_0000_1000,
    S_NMUL    = 12'b0000_0001_0000,
    S_DLOAD   = 12'b0000_0010_0000,
    S_DIVINIT = 12'b0000_0100_0000,
    S_DIV     = 12'b0000_1000_0000,
    S_QADD    = 12'b0001_0000_0000,
    S_PMUL    = 12'b0010_0000_0000,
    S_PADD    = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_t;

  state_t                                state_r, state_nxt;
  qxmm_pkg::act_t                        act_r, act_nxt;
  logic [qxmm_pkg::PWM_W-1:0]            pwm_r, pwm_nxt;
  logic [qxmm_pkg::LVL_W-1:0]            t_r, t_nxt;
  logic signed [qxmm_pkg::DEM_W-1:0]     r_r, r_nxt, p_r, p_nxt, y_r, y_nxt;
  logic signed [qxmm_pkg::M2_W-1:0]      m2_r [qxmm_pkg::NMOT];
  logic signed [qxmm_pkg::M2_W-1:0]      m2_nxt [qxmm_pkg::NMOT];
  logic [qxmm_pkg::DEN_W-1:0]            den_r, den_nxt;
  logic                                  desat_on_r, desat_on_nxt;
  logic [qxmm_pkg::MI_W-1:0]             mi_r, mi_nxt;
  logic [qxmm_pkg::NMOT-1:0]             tgt_r, tgt_nxt;
  logic [qxmm_pkg::LVL_W-1:0]            lvl_r, lvl_nxt;
  logic [qxmm_pkg::PWM_W-1:0]            pc_r, pc_nxt;
  logic signed [qxmm_pkg::MUL_W-1:0]     mul_r, mul_nxt;
  logic [qxmm_pkg::NUM_W-1:0]            rem_r, rem_nxt;
  logic [qxmm_pkg::DSH_W-1:0]            dsh_r, dsh_nxt;
  logic [qxmm_pkg::QUO_W-1:0]            q_r, q_nxt;
  logic                                  qneg_r, qneg_nxt;
  logic [qxmm_pkg::CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                                  pushed_r, pushed_nxt;

  logic                                  armed_r, armed_nxt;
  logic [qxmm_pkg::PWM_W-1:0]            pulse_r [qxmm_pkg::NMOT];
  logic [qxmm_pkg::PWM_W-1:0]            pulse_nxt [qxmm_pkg::NMOT];
  logic [qxmm_pkg::LVL_W-1:0]            level_r [qxmm_pkg::NMOT];
  logic [qxmm_pkg::LVL_W-1:0]            level_nxt [qxmm_pkg::NMOT];

  logic [qxmm_pkg::PWM_W-1:0]            floor_r, floor_nxt, ceil_r, ceil_nxt;
  logic [qxmm_pkg::LVL_W-1:0]            desat_min_r, desat_min_nxt, idle_r, idle_nxt;

  logic                                  out_valid_r, out_valid_nxt;
  logic [qxmm_pkg::PWM_W-1:0]            out_pwm_r [qxmm_pkg::NMOT];
  logic [qxmm_pkg::PWM_W-1:0]            out_pwm_nxt [qxmm_pkg::NMOT];
  logic [qxmm_pkg::LVL_W-1:0]            out_level_r [qxmm_pkg::NMOT];
  logic [qxmm_pkg::LVL_W-1:0]            out_level_nxt [qxmm_pkg::NMOT];
  logic                                  out_armed_r, out_armed_nxt;
  logic                                  out_pushed_r, out_pushed_nxt;

  // datapath
  logic                                  in_acc;
  logic signed [qxmm_pkg::M2_W-1:0]      tt2, rr, pp, yy;
  logic signed [qxmm_pkg::M2_W-1:0]      mx01, mx23, mx;
  logic signed [qxmm_pkg::M2_W-1:0]      m2_sel, m2_diff;
  logic signed [qxmm_pkg::DEN_W-1:0]     span;
  logic [qxmm_pkg::LVL_W-1:0]            one_minus_t;
  logic signed [qxmm_pkg::MUL_A_W-1:0]   mul_a;
  logic signed [qxmm_pkg::MUL_B_W-1:0]   mul_b;
  logic signed [qxmm_pkg::MUL_W-1:0]     prod;
  logic signed [qxmm_pkg::MUL_W-1:0]     psh;
  logic [qxmm_pkg::PWM_W-1:0]            pulse_val;
  logic [qxmm_pkg::MUL_W-1:0]            mag;
  logic [qxmm_pkg::PWM_W-1:0]            pdiff;
  logic [qxmm_pkg::NUM_W-1:0]            num;
  logic                                  div_sat;
  logic                                  div_ge;
  logic signed [qxmm_pkg::M2_W-1:0]      sq, tv;
  logic [qxmm_pkg::PWM_W-1:0]            pc_lo, pc_c;
  logic [qxmm_pkg::NMOT-1:0]             wr_mask;
  logic [qxmm_pkg::LVL_W-1:0]            wr_level;
  logic [qxmm_pkg::PWM_W-1:0]            wr_pulse;
  logic                                  wr_en;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE);

  assign tt2    = $signed(qxmm_pkg::M2_W'({t_r, 1'b0}));
  assign rr     = qxmm_pkg::M2_W'(r_r);
  assign pp     = qxmm_pkg::M2_W'(p_r);
  assign yy     = qxmm_pkg::M2_W'(y_r);
  assign mx01   = (m2_r[1] > m2_r[0]) ? m2_r[1] : m2_r[0];
  assign mx23   = (m2_r[3] > m2_r[2]) ? m2_r[3] : m2_r[2];
  assign mx     = (mx23 > mx01) ? mx23 : mx01;
  assign m2_sel = m2_r[mi_r];
  assign m2_diff = m2_sel - tt2;
  assign span   = $signed({1'b0, ceil_r}) - $signed({1'b0, floor_r});
  assign one_minus_t = qxmm_pkg::LVL_ONE - t_r;

  // shared multiplier: rescale numerator in S_NMUL, level to pulse otherwise
  always_comb begin
    if (state_r == S_NMUL) begin
      mul_a = qxmm_pkg::MUL_A_W'(m2_diff);
      mul_b = $signed({1'b0, one_minus_t});
    end else begin
      mul_a = qxmm_pkg::MUL_A_W'(span);
      mul_b = $signed({1'b0, lvl_r});
    end
  end
  assign prod = qxmm_pkg::MUL_W'(mul_a) * qxmm_pkg::MUL_W'(mul_b);

  // floor division by ONE of the registered product
  assign psh       = mul_r >>> qxmm_pkg::FRAC_BITS;
  assign pulse_val = qxmm_pkg::PWM_W'(psh) + floor_r;

  // divider set-up: magnitude of the numerator and overflow of the quotient width
  assign mag   = mul_r[qxmm_pkg::MUL_W-1] ? qxmm_pkg::MUL_W'(-mul_r) : qxmm_pkg::MUL_W'(mul_r);
  assign pdiff = pc_r - floor_r;
  assign num   = (act_r == qxmm_pkg::ACT_MIX) ? mag[qxmm_pkg::NUM_W-1:0]
                                              : {pdiff, {qxmm_pkg::FRAC_BITS{1'b0}}};
  assign div_sat = qxmm_pkg::DSH_W'(num) >= {den_r, {qxmm_pkg::QUO_W{1'b0}}};
  assign div_ge  = qxmm_pkg::DSH_W'(rem_r) >= dsh_r;

  assign sq = qneg_r ? -$signed(qxmm_pkg::M2_W'(q_r)) : $signed(qxmm_pkg::M2_W'(q_r));
  assign tv = $signed(qxmm_pkg::M2_W'(t_r)) + sq;

  // direct pulse raised to floor first, then lowered to ceiling
  assign pc_lo = (pwm_r < floor_r) ? floor_r : pwm_r;
  assign pc_c  = (pc_lo > ceil_r) ? ceil_r : pc_lo;

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    pwm_nxt       = pwm_r;
    t_nxt         = t_r;
    r_nxt         = r_r;
    p_nxt         = p_r;
    y_nxt         = y_r;
    m2_nxt        = m2_r;
    den_nxt       = den_r;
    desat_on_nxt  = desat_on_r;
    mi_nxt        = mi_r;
    tgt_nxt       = tgt_r;
    lvl_nxt       = lvl_r;
    pc_nxt        = pc_r;
    mul_nxt       = mul_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    q_nxt         = q_r;
    qneg_nxt      = qneg_r;
    cnt_nxt       = cnt_r;
    pushed_nxt    = pushed_r;
    armed_nxt     = armed_r;
    pulse_nxt     = pulse_r;
    level_nxt     = level_r;
    floor_nxt     = floor_r;
    ceil_nxt      = ceil_r;
    desat_min_nxt = desat_min_r;
    idle_nxt      = idle_r;
    out_valid_nxt = out_valid_r;
    out_pwm_nxt   = out_pwm_r;
    out_level_nxt = out_level_r;
    out_armed_nxt = out_armed_r;
    out_pushed_nxt = out_pushed_r;
    wr_en         = 1'b0;
    wr_mask       = tgt_r;
    wr_level      = lvl_r;
    wr_pulse      = pulse_val;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      unique case (qxmm_pkg::cfg_reg_t'(cfg_index))
        qxmm_pkg::CFG_PWM_FLOOR:   floor_nxt     = cfg_data;
        qxmm_pkg::CFG_PWM_CEILING: ceil_nxt      = cfg_data;
        qxmm_pkg::CFG_DESAT_MIN:   desat_min_nxt = cfg_data[qxmm_pkg::LVL_W-1:0];
        qxmm_pkg::CFG_IDLE_LEVEL:  idle_nxt      = cfg_data[qxmm_pkg::LVL_W-1:0];
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          act_nxt    = qxmm_pkg::act_t'(in_action);
          pwm_nxt    = in_pwm_value;
          t_nxt      = qxmm_pkg::clamp_thr(in_throttle_cmd);
          r_nxt      = qxmm_pkg::clamp_dem(in_roll_cmd);
          p_nxt      = qxmm_pkg::clamp_dem(in_pitch_cmd);
          y_nxt      = qxmm_pkg::clamp_dem(in_yaw_cmd);
          pushed_nxt = 1'b0;
          mi_nxt     = '0;
          state_nxt  = S_DONE;
          unique case (qxmm_pkg::act_t'(in_action))
            qxmm_pkg::ACT_MIX: begin
              state_nxt = S_SUM;
            end
            qxmm_pkg::ACT_ARM: begin
              armed_nxt = 1'b1;
            end
            qxmm_pkg::ACT_DISARM: begin
              armed_nxt  = 1'b0;
              pushed_nxt = 1'b1;
              for (int i = 0; i < qxmm_pkg::NMOT; i++) begin
                level_nxt[i] = '0;
                pulse_nxt[i] = floor_r;
              end
            end
            qxmm_pkg::ACT_SET_PWM: begin
              if (!in_motor_index[qxmm_pkg::IDX_W-1]) begin
                tgt_nxt   = qxmm_pkg::NMOT'(1) << in_motor_index[qxmm_pkg::MI_W-1:0];
                state_nxt = S_DLOAD;
              end
            end
            qxmm_pkg::ACT_SET_ALL: begin
              tgt_nxt   = '1;
              state_nxt = S_DLOAD;
            end
            qxmm_pkg::ACT_IDLE: begin
              tgt_nxt   = '1;
              lvl_nxt   = (idle_r > qxmm_pkg::LVL_ONE) ? qxmm_pkg::LVL_ONE : idle_r;
              state_nxt = S_PMUL;
            end
            qxmm_pkg::ACT_STOP: begin
              pushed_nxt = 1'b1;
              for (int i = 0; i < qxmm_pkg::NMOT; i++) begin
                level_nxt[i] = '0;
                pulse_nxt[i] = floor_r;
              end
            end
            qxmm_pkg::ACT_UPDATE: begin
              pushed_nxt = 1'b1;
              if (!armed_r) begin
                for (int i = 0; i < qxmm_pkg::NMOT; i++) begin
                  level_nxt[i] = '0;
                  pulse_nxt[i] = floor_r;
                end
              end
            end
          endcase
        end
      end

      // x pattern at twice the scale so the half gains stay exact
      S_SUM: begin
        m2_nxt[0] = tt2 - rr + pp + yy;
        m2_nxt[1] = tt2 + rr + pp - yy;
        m2_nxt[2] = tt2 + rr - pp + yy;
        m2_nxt[3] = tt2 - rr - pp - yy;
        state_nxt = S_MAX;
      end

      S_MAX: begin
        desat_on_nxt = (mx > qxmm_pkg::M2_W'(2 * qxmm_pkg::ONE)) && (t_r > desat_min_r);
        den_nxt      = qxmm_pkg::DEN_W'(mx - tt2);
        state_nxt    = ((mx > qxmm_pkg::M2_W'(2 * qxmm_pkg::ONE)) && (t_r > desat_min_r))
                       ? S_NMUL : S_LVL;
      end

      S_LVL: begin
        if (m2_sel < 0) begin
          lvl_nxt = '0;
        end else if (m2_sel[qxmm_pkg::M2_W-1:1] > (qxmm_pkg::M2_W-1)'(qxmm_pkg::ONE)) begin
          lvl_nxt = qxmm_pkg::LVL_ONE;
        end else begin
          lvl_nxt = m2_sel[qxmm_pkg::LVL_W:1];
        end
        state_nxt = S_PMUL;
      end

      S_NMUL: begin
        mul_nxt   = prod;
        state_nxt = S_DIVINIT;
      end

      S_DLOAD: begin
        pc_nxt = pc_c;
        if ((span > 0) && (pc_c > floor_r)) begin
          den_nxt   = qxmm_pkg::DEN_W'(span);
          state_nxt = S_DIVINIT;
        end else begin
          q_nxt     = '0;
          state_nxt = S_QADD;
        end
      end

      S_DIVINIT: begin
        qneg_nxt = (act_r == qxmm_pkg::ACT_MIX) && mul_r[qxmm_pkg::MUL_W-1];
        if (div_sat) begin
          // quotient beyond any level, the clamp after it gives the same answer
          q_nxt     = '1;
          state_nxt = S_QADD;
        end else begin
          rem_nxt   = num;
          dsh_nxt   = {1'b0, den_r, {(qxmm_pkg::QUO_W-1){1'b0}}};
          q_nxt     = '0;
          cnt_nxt   = qxmm_pkg::CNT_W'(qxmm_pkg::QUO_W - 1);
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        if (div_ge) begin
          rem_nxt = rem_r - dsh_r[qxmm_pkg::NUM_W-1:0];
        end
        q_nxt   = {q_r[qxmm_pkg::QUO_W-2:0], div_ge};
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_QADD;
        end
      end

      S_QADD: begin
        if (act_r == qxmm_pkg::ACT_MIX) begin
          if (tv < 0) begin
            lvl_nxt = '0;
          end else if (tv > qxmm_pkg::M2_W'(qxmm_pkg::ONE)) begin
            lvl_nxt = qxmm_pkg::LVL_ONE;
          end else begin
            lvl_nxt = tv[qxmm_pkg::LVL_W-1:0];
          end
          state_nxt = S_PMUL;
        end else begin
          wr_en     = 1'b1;
          wr_mask   = tgt_r;
          wr_pulse  = pc_r;
          wr_level  = (q_r > qxmm_pkg::QUO_W'(qxmm_pkg::ONE)) ? qxmm_pkg::LVL_ONE
                                                             : q_r[qxmm_pkg::LVL_W-1:0];
          state_nxt = S_DONE;
        end
      end

      S_PMUL: begin
        mul_nxt   = prod;
        state_nxt = S_PADD;
      end

      S_PADD: begin
        wr_en    = 1'b1;
        wr_level = lvl_r;
        wr_pulse = pulse_val;
        if (act_r == qxmm_pkg::ACT_MIX) begin
          wr_mask = qxmm_pkg::NMOT'(1) << mi_r;
          if (mi_r != qxmm_pkg::MI_W'(qxmm_pkg::NMOT - 1)) begin
            mi_nxt    = mi_r + 1'b1;
            state_nxt = desat_on_r ? S_NMUL : S_LVL;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          wr_mask   = tgt_r;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // hold here while the previous result is still waiting
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_pwm_nxt    = pulse_r;
          out_level_nxt  = level_r;
          out_armed_nxt  = armed_r;
          out_pushed_nxt = pushed_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (wr_en) begin
      for (int i = 0; i < qxmm_pkg::NMOT; i++) begin
        if (wr_mask[i]) begin
          level_nxt[i] = wr_level;
          pulse_nxt[i] = wr_pulse;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      armed_r     <= 1'b0;
      out_valid_r <= 1'b0;
      floor_r     <= qxmm_pkg::PWM_FLOOR_RST;
      ceil_r      <= qxmm_pkg::PWM_CEILING_RST;
      desat_min_r <= qxmm_pkg::DESAT_MIN_RST;
      idle_r      <= qxmm_pkg::IDLE_LEVEL_RST;
      for (int i = 0; i < qxmm_pkg::NMOT; i++) begin
        pulse_r[i] <= qxmm_pkg::PWM_FLOOR_RST;
        level_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      armed_r     <= armed_nxt;
      out_valid_r <= out_valid_nxt;
      floor_r     <= floor_nxt;
      ceil_r      <= ceil_nxt;
      desat_min_r <= desat_min_nxt;
      idle_r      <= idle_nxt;
      pulse_r     <= pulse_nxt;
      level_r     <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    pwm_r        <= pwm_nxt;
    t_r          <= t_nxt;
    r_r          <= r_nxt;
    p_r          <= p_nxt;
    y_r          <= y_nxt;
    m2_r         <= m2_nxt;
    den_r        <= den_nxt;
    desat_on_r   <= desat_on_nxt;
    mi_r         <= mi_nxt;
    tgt_r        <= tgt_nxt;
    lvl_r        <= lvl_nxt;
    pc_r         <= pc_nxt;
    mul_r        <= mul_nxt;
    rem_r        <= rem_nxt;
    dsh_r        <= dsh_nxt;
    q_r          <= q_nxt;
    qneg_r       <= qneg_nxt;
    cnt_r        <= cnt_nxt;
    pushed_r     <= pushed_nxt;
    out_pwm_r    <= out_pwm_nxt;
    out_level_r  <= out_level_nxt;
    out_armed_r  <= out_armed_nxt;
    out_pushed_r <= out_pushed_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_pwm_motor1    = out_pwm_r[0];
  assign out_pwm_motor2    = out_pwm_r[1];
  assign out_pwm_motor3    = out_pwm_r[2];
  assign out_pwm_motor4    = out_pwm_r[3];
  assign out_level_motor1  = out_level_r[0];
  assign out_level_motor2  = out_level_r[1];
  assign out_level_motor3  = out_level_r[2];
  assign out_level_motor4  = out_level_r[3];
  assign out_is_armed      = out_armed_r;
  assign out_levels_pushed = out_pushed_r;

`ifndef SYNTH
  a_level_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_level_r[0] <= qxmm_pkg::LVL_ONE) && (out_level_r[1] <= qxmm_pkg::LVL_ONE)
                 && (out_level_r[2] <= qxmm_pkg::LVL_ONE) && (out_level_r[3] <= qxmm_pkg::LVL_ONE))
    else $error("motor level above full scale");

  a_pushed_disarmed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pushed_r && !out_armed_r) |->
      (out_level_r[0] == '0) && (out_level_r[1] == '0)
   && (out_level_r[2] == '0) && (out_level_r[3] == '0))
    else $error("levels pushed while disarmed but not zero");

  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> ((qxmm_pkg::DSH_W + 1)'(rem_r) < {dsh_r, 1'b0}))
    else $error("divider remainder out of range");
`endif

endmodule

[verif/quad_x_motor_mixer_chk.sv]
module quad_x_motor_mixer_chk
  import qxmm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [ACT_W-1:0]         in_action,
  input  logic signed [CMD_W-1:0]  in_throttle_cmd,
  input  logic signed [CMD_W-1:0]  in_roll_cmd,
  input  logic signed [CMD_W-1:0]  in_pitch_cmd,
  input  logic signed [CMD_W-1:0]  in_yaw_cmd,
  input  logic [IDX_W-1:0]         in_motor_index,
  input  logic [PWM_W-1:0]         in_pwm_value,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [PWM_W-1:0]         out_pwm_motor1,
  input  logic [PWM_W-1:0]         out_pwm_motor2,
  input  logic [PWM_W-1:0]         out_pwm_motor3,
  input  logic [PWM_W-1:0]         out_pwm_motor4,
  input  logic [LVL_W-1:0]         out_level_motor1,
  input  logic [LVL_W-1:0]         out_level_motor2,
  input  logic [LVL_W-1:0]         out_level_motor3,
  input  logic [LVL_W-1:0]         out_level_motor4,
  input  logic                     out_is_armed,
  input  logic                     out_levels_pushed,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DAT_W-1:0]     cfg_data,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NMOT-1:0][PWM_W-1:0] pulse;
    logic [NMOT-1:0][LVL_W-1:0] level;
    logic                       armed;
    logic                       pushed;
  } motor_report_t;

  motor_report_t     motors_q;
  motor_report_t     reports_due[$];
  logic [PWM_W-1:0]  floor_q;
  logic [PWM_W-1:0]  ceil_q;
  logic [LVL_W-1:0]  desat_q;
  logic [LVL_W-1:0]  idle_q;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic longint clampl(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // floor of level * span / ONE, span may be negative with inverted limits
  function automatic logic [PWM_W-1:0] level_pulse(longint lvl);
    longint span;
    span = longint'(ceil_q) - longint'(floor_q);
    return PWM_W'(longint'(floor_q) + ((lvl * span) >>> FRAC_BITS));
  endfunction

  function automatic void drive_motor(int i, longint lvl);
    motors_q.level[i] = LVL_W'(lvl);
    motors_q.pulse[i] = level_pulse(lvl);
  endfunction

  function automatic void stop_motors();
    for (int i = 0; i < NMOT; i++) begin
      motors_q.level[i] = '0;
      motors_q.pulse[i] = floor_q;
    end
  endfunction

  function automatic void direct_pulse(int i, logic [PWM_W-1:0] raw);
    longint p;
    longint span;
    longint lvl;
    p = longint'(raw);
    if (p < longint'(floor_q)) p = longint'(floor_q);
    if (p > longint'(ceil_q)) p = longint'(ceil_q);
    span = longint'(ceil_q) - longint'(floor_q);
    lvl = 0;
    if (span > 0 && p > longint'(floor_q))
      lvl = clampl(((p - longint'(floor_q)) * ONE) / span, 0, ONE);
    motors_q.pulse[i] = PWM_W'(p);
    motors_q.level[i] = LVL_W'(lvl);
  endfunction

  function automatic void mix_motors();
    longint t, r, p, y, mx, den, num, q;
    longint m2[NMOT];
    t = clampl(longint'(in_throttle_cmd), 0, ONE);
    r = clampl(longint'(in_roll_cmd), -ONE, ONE);
    p = clampl(longint'(in_pitch_cmd), -ONE, ONE);
    y = clampl(longint'(in_yaw_cmd), -ONE, ONE);
    // demands kept at twice the scale so the half gains stay exact
    m2[0] = 2 * t - r + p + y;
    m2[1] = 2 * t + r + p - y;
    m2[2] = 2 * t + r - p + y;
    m2[3] = 2 * t - r - p - y;
    mx = m2[0];
    for (int i = 1; i < NMOT; i++)
      if (m2[i] > mx) mx = m2[i];
    if (mx > 2 * ONE && t > longint'(desat_q)) begin
      den = mx - 2 * t;
      for (int i = 0; i < NMOT; i++) begin
        num = (m2[i] - 2 * t) * (ONE - t);
        q = num / den;
        drive_motor(i, clampl(t + q, 0, ONE));
      end
    end else begin
      for (int i = 0; i < NMOT; i++)
        drive_motor(i, clampl((m2[i] < 0) ? 0 : (m2[i] >>> 1), 0, ONE));
    end
  endfunction

  function automatic motor_report_t run_command();
    motor_report_t rep;
    logic          pushed;
    pushed = 1'b0;
    case (act_t'(in_action))
      ACT_MIX:     mix_motors();
      ACT_ARM:     motors_q.armed = 1'b1;
      ACT_DISARM: begin
        motors_q.armed = 1'b0;
        stop_motors();
        pushed = 1'b1;
      end
      ACT_SET_PWM: if (in_motor_index < NMOT) direct_pulse(int'(in_motor_index), in_pwm_value);
      ACT_SET_ALL: for (int i = 0; i < NMOT; i++) direct_pulse(i, in_pwm_value);
      ACT_IDLE:    for (int i = 0; i < NMOT; i++) drive_motor(i, clampl(idle_q, 0, ONE));
      ACT_STOP: begin
        stop_motors();
        pushed = 1'b1;
      end
      ACT_UPDATE: begin
        if (!motors_q.armed) stop_motors();
        pushed = 1'b1;
      end
    endcase
    rep = motors_q;
    rep.pushed = pushed;
    return rep;
  endfunction

  function automatic void check_field(string what, longint want, longint got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    end
  endfunction

  function automatic void check_report(motor_report_t got);
    motor_report_t want;
    if (reports_due.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("%0t: result item with none expected", $realtime);
      return;
    end
    want = reports_due.pop_front();
    for (int i = 0; i < NMOT; i++) begin
      check_field($sformatf("pwm_motor%0d", i + 1), want.pulse[i], got.pulse[i]);
      check_field($sformatf("level_motor%0d", i + 1), want.level[i], got.level[i]);
    end
    check_field("is_armed", want.armed, got.armed);
    check_field("levels_pushed", want.pushed, got.pushed);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      floor_q        = PWM_FLOOR_RST;
      ceil_q         = PWM_CEILING_RST;
      desat_q        = DESAT_MIN_RST;
      idle_q         = IDLE_LEVEL_RST;
      motors_q       = '0;
      stop_motors();
      reports_due.delete();
    end else begin
      // a result leaving now belongs to an earlier item, so pop before push
      if (out_valid && !out_stall)
        check_report({out_pwm_motor4, out_pwm_motor3, out_pwm_motor2, out_pwm_motor1,
                      out_level_motor4, out_level_motor3, out_level_motor2, out_level_motor1,
                      out_is_armed, out_levels_pushed});
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_PWM_FLOOR:   floor_q = cfg_data;
          CFG_PWM_CEILING: ceil_q  = cfg_data;
          CFG_DESAT_MIN:   desat_q = cfg_data[LVL_W-1:0];
          CFG_IDLE_LEVEL:  idle_q  = cfg_data[LVL_W-1:0];
        endcase
      end
      if (in_valid && !in_stall)
        reports_due.push_back(run_command());
    end
    pending = reports_due.size();
  end

endmodule

[verif/quad_x_motor_mixer_tb.sv]
module quad_x_motor_mixer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qxmm_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 300;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [ACT_W-1:0]         in_action;
  logic signed [CMD_W-1:0]  in_throttle_cmd;
  logic signed [CMD_W-1:0]  in_roll_cmd;
  logic signed [CMD_W-1:0]  in_pitch_cmd;
  logic signed [CMD_W-1:0]  in_yaw_cmd;
  logic [IDX_W-1:0]         in_motor_index;
  logic [PWM_W-1:0]         in_pwm_value;
  logic                     out_valid;
  logic                     out_stall;
  logic [PWM_W-1:0]         out_pwm_motor1;
  logic [PWM_W-1:0]         out_pwm_motor2;
  logic [PWM_W-1:0]         out_pwm_motor3;
  logic [PWM_W-1:0]         out_pwm_motor4;
  logic [LVL_W-1:0]         out_level_motor1;
  logic [LVL_W-1:0]         out_level_motor2;
  logic [LVL_W-1:0]         out_level_motor3;
  logic [LVL_W-1:0]         out_level_motor4;
  logic                     out_is_armed;
  logic                     out_levels_pushed;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DAT_W-1:0]     cfg_data;

  int  fail_count;
  int  pending;
  int  cycle_count = 0;
  bit  tx_gaps = 1'b1;
  bit  rx_gaps = 1'b1;
  int  cur_floor = 1000;
  int  cur_ceil = 2000;

  quad_x_motor_mixer uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_throttle_cmd   (in_throttle_cmd),
    .in_roll_cmd       (in_roll_cmd),
    .in_pitch_cmd      (in_pitch_cmd),
    .in_yaw_cmd        (in_yaw_cmd),
    .in_motor_index    (in_motor_index),
    .in_pwm_value      (in_pwm_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pwm_motor1    (out_pwm_motor1),
    .out_pwm_motor2    (out_pwm_motor2),
    .out_pwm_motor3    (out_pwm_motor3),
    .out_pwm_motor4    (out_pwm_motor4),
    .out_level_motor1  (out_level_motor1),
    .out_level_motor2  (out_level_motor2),
    .out_level_motor3  (out_level_motor3),
    .out_level_motor4  (out_level_motor4),
    .out_is_armed      (out_is_armed),
    .out_levels_pushed (out_levels_pushed),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  quad_x_motor_mixer_chk chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_throttle_cmd   (in_throttle_cmd),
    .in_roll_cmd       (in_roll_cmd),
    .in_pitch_cmd      (in_pitch_cmd),
    .in_yaw_cmd        (in_yaw_cmd),
    .in_motor_index    (in_motor_index),
    .in_pwm_value      (in_pwm_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pwm_motor1    (out_pwm_motor1),
    .out_pwm_motor2    (out_pwm_motor2),
    .out_pwm_motor3    (out_pwm_motor3),
    .out_pwm_motor4    (out_pwm_motor4),
    .out_level_motor1  (out_level_motor1),
    .out_level_motor2  (out_level_motor2),
    .out_level_motor3  (out_level_motor3),
    .out_level_motor4  (out_level_motor4),
    .out_is_armed      (out_is_armed),
    .out_levels_pushed (out_levels_pushed),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side back-pressure in bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // called at a falling edge, returns at a falling edge with in_valid still high
  task automatic send_cmd(input act_t act, input logic signed [CMD_W-1:0] thr,
                          input logic signed [CMD_W-1:0] roll,
                          input logic signed [CMD_W-1:0] pitch,
                          input logic signed [CMD_W-1:0] yaw,
                          input logic [IDX_W-1:0] idx, input logic [PWM_W-1:0] pwm);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_action       = act;
    in_throttle_cmd = thr;
    in_roll_cmd     = roll;
    in_pitch_cmd    = pitch;
    in_yaw_cmd      = yaw;
    in_motor_index  = idx;
    in_pwm_value    = pwm;
    in_valid        = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_limits(input int fl, input int ce, input int desat, input int idle);
    drain();
    write_reg(CFG_PWM_FLOOR, CFG_DAT_W'(fl));
    write_reg(CFG_PWM_CEILING, CFG_DAT_W'(ce));
    write_reg(CFG_DESAT_MIN, CFG_DAT_W'(desat));
    write_reg(CFG_IDLE_LEVEL, CFG_DAT_W'(idle));
    cur_floor = fl;
    cur_ceil  = ce;
  endtask

  // mostly near the useful range, sometimes anything at all
  function automatic logic signed [CMD_W-1:0] pick_cmd(int lo, int hi);
    if ($urandom_range(0, 9) < 8) return CMD_W'(lo + int'($urandom_range(0, hi - lo)));
    return CMD_W'($urandom);
  endfunction

  function automatic logic [PWM_W-1:0] pick_pwm();
    int lo;
    int hi;
    lo = (cur_floor < cur_ceil) ? cur_floor : cur_ceil;
    hi = (cur_floor < cur_ceil) ? cur_ceil : cur_floor;
    if ($urandom_range(0, 1) == 0) return PWM_W'($urandom);
    return PWM_W'(lo - 40 + int'($urandom_range(0, hi - lo + 80)));
  endfunction

  task automatic send_random();
    int   pick;
    act_t act;
    pick = $urandom_range(0, 99);
    if (pick < 45)      act = ACT_MIX;
    else if (pick < 53) act = ACT_ARM;
    else if (pick < 58) act = ACT_DISARM;
    else if (pick < 70) act = ACT_SET_PWM;
    else if (pick < 78) act = ACT_SET_ALL;
    else if (pick < 85) act = ACT_IDLE;
    else if (pick < 90) act = ACT_STOP;
    else                act = ACT_UPDATE;
    send_cmd(act, pick_cmd(-150, 4300), pick_cmd(-4400, 4400), pick_cmd(-4400, 4400),
             pick_cmd(-4400, 4400), IDX_W'($urandom_range(0, 7)), pick_pwm());
  endtask

  task automatic run_phase(input int n);
    repeat (n) send_random();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_action       = ACT_MIX;
    in_throttle_cmd = '0;
    in_roll_cmd     = '0;
    in_pitch_cmd    = '0;
    in_yaw_cmd      = '0;
    in_motor_index  = '0;
    in_pwm_value    = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_PWM_FLOOR;
    cfg_data        = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed items on the reset settings
    send_cmd(ACT_UPDATE, 0, 0, 0, 0, 0, 0);
    send_cmd(ACT_ARM, 0, 0, 0, 0, 0, 0);
    send_cmd(ACT_MIX, 0, 0, 0, 0, 0, 0);
    send_cmd(ACT_MIX, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 0, 0);
    send_cmd(ACT_MIX, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 0, 0);
    send_cmd(ACT_MIX, 4096, 4096, 4096, 4096, 0, 0);
    // throttle at the rescaling threshold and just above it
    send_cmd(ACT_MIX, 205, 4096, 0, 0, 0, 0);
    send_cmd(ACT_MIX, 206, 4096, 0, 0, 0, 0);
    send_cmd(ACT_MIX, 2048, -1000, 500, -300, 0, 0);
    send_cmd(ACT_SET_PWM, 0, 0, 0, 0, 0, 16'h0000);
    send_cmd(ACT_SET_PWM, 0, 0, 0, 0, 1, 16'hFFFF);
    send_cmd(ACT_SET_PWM, 0, 0, 0, 0, 2, 1500);
    send_cmd(ACT_SET_PWM, 0, 0, 0, 0, 3, 1001);
    send_cmd(ACT_SET_PWM, 0, 0, 0, 0, 4, 1500);
    send_cmd(ACT_SET_PWM, 0, 0, 0, 0, 7, 1700);
    send_cmd(ACT_SET_ALL, 0, 0, 0, 0, 0, 1999);
    send_cmd(ACT_IDLE, 0, 0, 0, 0, 0, 0);
    send_cmd(ACT_UPDATE, 0, 0, 0, 0, 0, 0);
    send_cmd(ACT_STOP, 0, 0, 0, 0, 0, 0);
    send_cmd(ACT_DISARM, 0, 0, 0, 0, 0, 0);
    send_cmd(ACT_MIX, 3000, 1000, -2000, 700, 0, 0);
    send_cmd(ACT_UPDATE, 0, 0, 0, 0, 0, 0);

    // widest span, saturated mixes rescaled whenever throttle is above zero
    set_limits(0, 65535, 0, 4096);
    run_phase(PHASE_ITEMS);
    // inverted limits, no rescaling, idle level past full scale
    set_limits(65535, 0, 4096, 8191);
    run_phase(PHASE_ITEMS);
    // equal limits
    set_limits(1500, 1500, 4095, 0);
    run_phase(PHASE_ITEMS);
    set_limits(1000, 2000, 205, 246);
    run_phase(PHASE_ITEMS);
    begin
      int fl;
      fl = $urandom_range(0, 30000);
      set_limits(fl, fl + int'($urandom_range(1, 30000)), $urandom_range(0, 4096),
                 $urandom_range(0, 4096));
    end
    run_phase(PHASE_ITEMS);
    begin
      int fl;
      fl = $urandom_range(0, 60000);
      set_limits(fl, fl + int'($urandom_range(1, 65535 - fl)), $urandom_range(0, 4096),
                 $urandom_range(0, 4096));
    end
    // closing stretch at full rate on both sides
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_phase(PHASE_ITEMS);

    drain();
    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[quad_x_motor_mixer.f]
rtl/core/qxmm_pkg.sv
rtl/core/quad_x_motor_mixer.sv
verif/quad_x_motor_mixer_chk.sv
verif/quad_x_motor_mixer_tb.sv
